// File: src/ggc_pkg.sv
// ggc_pkg: shared types and constants of the greedy graph coloring check
// used by the top level, the adjacency store and the port checker
`default_nettype none

package ggc_pkg;

  // width of the vertex number fields and of the configuration registers
  localparam int unsigned FieldW = 5;

  // configuration register indexes
  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_COLOR_LIMIT  = 1'b1;

  // reset values of the configuration registers
  localparam logic [FieldW-1:0] VertexCountRst = 5'd16;
  localparam logic [FieldW-1:0] ColorLimitRst  = 5'd16;

  // largest value that the colors used field can show
  localparam logic [FieldW-1:0] ColorsSat = 5'd31;

  // control from the sequencer to the adjacency store
  typedef struct packed {
    logic              set;   // store the edge from..to when it is in range
    logic              clr;   // clear the whole graph
    logic [FieldW-1:0] from;
    logic [FieldW-1:0] to;
  } adj_ctrl_t;

endpackage

`default_nettype wire

// File: src/ggc_adj.sv
// ggc_adj: adjacency matrix of the graph, one row of flip-flops per vertex
// depends on ggc_pkg for the control struct and field width
`default_nettype none

module ggc_adj
  import ggc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 16,
  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1)
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire adj_ctrl_t               ctrl_i,
  input  wire logic [CW-1:0]           n_i,
  input  wire logic [VW-1:0]           rd_addr_i,
  output logic      [MAX_VERTICES-1:0] rd_row_o
);

  logic [MAX_VERTICES-1:0] rows_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] live;
  logic [FieldW-1:0]       x_m1;
  logic [FieldW-1:0]       y_m1;
  logic [VW-1:0]           xi;
  logic [VW-1:0]           yi;
  logic [FieldW:0]         x_ext;
  logic [FieldW:0]         y_ext;
  logic [FieldW:0]         n_ext;
  logic                    edge_ok;

  // vertices that take part in the current graph
  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      live[j] = (CW'(j) < n_i);
    end
  end

  // range check: no self-loop, both ends within 1..n
  assign x_ext   = {1'b0, ctrl_i.from};
  assign y_ext   = {1'b0, ctrl_i.to};
  assign n_ext   = (FieldW + 1)'(n_i);
  assign edge_ok = ctrl_i.set && (ctrl_i.from != ctrl_i.to) &&
                   (ctrl_i.from != '0) && (ctrl_i.to != '0) &&
                   (x_ext <= n_ext) && (y_ext <= n_ext);
  assign x_m1    = ctrl_i.from - 1'b1;
  assign y_m1    = ctrl_i.to - 1'b1;
  assign xi      = x_m1[VW-1:0];
  assign yi      = y_m1[VW-1:0];

  // set both symmetric bits, or clear everything at the end of a graph
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        rows_q[r] <= '0;
      end
    end else if (ctrl_i.clr) begin
      for (int r = 0; r < MAX_VERTICES; r++) begin
        rows_q[r] <= '0;
      end
    end else if (edge_ok) begin
      rows_q[xi][yi] <= 1'b1;
      rows_q[yi][xi] <= 1'b1;
    end
  end

  // one row read per cycle, masked to the live vertices
  assign rd_row_o = rows_q[rd_addr_i] & live;

endmodule

`default_nettype wire

// File: src/greedy_graph_coloring_check.sv
// greedy_graph_coloring_check: top level, edge intake and coloring sequencer
// depends on ggc_pkg and ggc_adj
`default_nettype none

// Collects one undirected edge per item and, on the item marked last, colors
// the graph the Welsh-Powell way and returns the number of colors used and
// whether it is within color_limit. An edge item without the last mark
// starts no pass. A last item starts a pass over the active vertices: a
// degree count (one row popcount a cycle), a ranking of the vertices by
// falling degree (one compare a cycle), then the coloring steps (one row
// merge a cycle) and a final step that posts the result; an empty graph
// takes that last step only. The sequencer and its single adjacency row
// read port set these rates. Posting is held for as long as an earlier
// result is still stalled at the output. Input stays stalled during the
// pass; the result sits in an output register, so the next graph may load
// while it waits. The graph is cleared when the result is posted.
module greedy_graph_coloring_check
  import ggc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [FieldW-1:0] cfg_data_i,
  // input items
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [FieldW-1:0] edge_from_i,
  input  wire logic [FieldW-1:0] edge_to_i,
  input  wire logic              has_edge_i,
  input  wire logic              last_edge_i,
  // result items
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [FieldW-1:0] colors_used_o,
  output logic                   fits_limit_o
);

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DEG    = 3'd1;
  localparam logic [2:0] ST_RANK   = 3'd2;
  localparam logic [2:0] ST_PICK   = 3'd3;
  localparam logic [2:0] ST_SCAN   = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  // popcount of one masked row
  function automatic logic [CW-1:0] row_count(input logic [MAX_VERTICES-1:0] bits);
    logic [CW-1:0] c;
    c = '0;
    for (int b = 0; b < MAX_VERTICES; b++) begin
      c = c + CW'(bits[b]);
    end
    return c;
  endfunction

  logic [2:0]              state_q, state_d;
  logic [FieldW-1:0]       vcount_q;
  logic [FieldW-1:0]       climit_q;
  logic [VW-1:0]           i_q, i_d;
  logic [VW-1:0]           d_q, d_d;
  logic [VW-1:0]           k_q, k_d;
  logic [VW-1:0]           p_q, p_d;
  logic [VW-1:0]           q_q, q_d;
  logic [CW-1:0]           total_q, total_d;
  logic [MAX_VERTICES-1:0] colored_q, colored_d;
  logic [MAX_VERTICES-1:0] nbrs_q, nbrs_d;
  logic [CW-1:0]           deg_q   [MAX_VERTICES];
  logic [VW-1:0]           order_q [MAX_VERTICES];
  logic                    out_valid_q, out_valid_d;
  logic [FieldW-1:0]       colors_q;
  logic                    fits_q;

  logic [CW-1:0]           n_w;
  logic [CW-1:0]           nm1;
  logic                    in_acc;
  logic                    deg_we;
  logic                    ord_we;
  logic                    post;
  logic [VW-1:0]           ord_addr;
  logic [VW-1:0]           vtx;
  logic [VW-1:0]           adj_addr;
  logic [MAX_VERTICES-1:0] row;
  logic [CW-1:0]           row_deg;
  logic [FieldW:0]         total_ext;
  adj_ctrl_t               adj_ctrl;

  // active vertex count, capped at the array size
  assign n_w = ({1'b0, vcount_q} > (FieldW + 1)'(MAX_VERTICES)) ?
               CW'(MAX_VERTICES) : CW'(vcount_q);
  assign nm1 = n_w - 1'b1;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VertexCountRst;
      climit_q <= ColorLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_VERTEX_COUNT: vcount_q <= cfg_data_i;
        CFG_COLOR_LIMIT:  climit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ranked vertex under the cursor, and the row read address
  assign ord_addr = (state_q == ST_SCAN) ? q_q : p_q;
  assign vtx      = order_q[ord_addr];
  assign adj_addr = (state_q == ST_DEG) ? i_q : vtx;
  assign row_deg  = row_count(row);

  assign adj_ctrl.set  = in_acc && has_edge_i;
  assign adj_ctrl.clr  = post;
  assign adj_ctrl.from = edge_from_i;
  assign adj_ctrl.to   = edge_to_i;

  ggc_adj #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_adj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (adj_ctrl),
    .n_i      (n_w),
    .rd_addr_i(adj_addr),
    .rd_row_o (row)
  );

  // sequencer: degree count, ranking, then greedy class building
  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    d_d         = d_q;
    k_d         = k_q;
    p_d         = p_q;
    q_d         = q_q;
    total_d     = total_q;
    colored_d   = colored_q;
    nbrs_d      = nbrs_q;
    deg_we      = 1'b0;
    ord_we      = 1'b0;
    post        = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && last_edge_i) begin
          i_d       = '0;
          total_d   = '0;
          colored_d = '0;
          state_d   = (n_w == '0) ? ST_FINISH : ST_DEG;
        end
      end
      ST_DEG: begin
        deg_we = 1'b1;
        if (CW'(i_q) == nm1) begin
          i_d     = '0;
          d_d     = nm1[VW-1:0];
          k_d     = '0;
          state_d = ST_RANK;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_RANK: begin
        if (deg_q[i_q] == CW'(d_q)) begin
          ord_we = 1'b1;
          k_d    = k_q + 1'b1;
        end
        if (CW'(i_q) == nm1) begin
          i_d = '0;
          if (d_q == '0) begin
            p_d     = '0;
            state_d = ST_PICK;
          end else begin
            d_d = d_q - 1'b1;
          end
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      ST_PICK: begin
        if (colored_q[vtx]) begin
          if (CW'(p_q) == nm1) begin
            state_d = ST_FINISH;
          end else begin
            p_d = p_q + 1'b1;
          end
        end else begin
          total_d        = total_q + 1'b1;
          colored_d[vtx] = 1'b1;
          nbrs_d         = row;
          if (CW'(p_q) == nm1) begin
            state_d = ST_FINISH;
          end else begin
            q_d     = p_q + 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (!colored_q[vtx] && !nbrs_q[vtx]) begin
          colored_d[vtx] = 1'b1;
          nbrs_d         = nbrs_q | row;
        end
        if (CW'(q_q) == nm1) begin
          if (CW'(p_q) == nm1) begin
            state_d = ST_FINISH;
          end else begin
            p_d     = p_q + 1'b1;
            state_d = ST_PICK;
          end
        end else begin
          q_d = q_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!(out_valid_q && out_stall_i)) begin
          post        = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      d_q         <= '0;
      k_q         <= '0;
      p_q         <= '0;
      q_q         <= '0;
      total_q     <= '0;
      colored_q   <= '0;
      nbrs_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      d_q         <= d_d;
      k_q         <= k_d;
      p_q         <= p_d;
      q_q         <= q_d;
      total_q     <= total_d;
      colored_q   <= colored_d;
      nbrs_q      <= nbrs_d;
      out_valid_q <= out_valid_d;
    end
  end

  // degree and ranking tables
  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_q[i_q] <= row_deg;
    end
    if (ord_we) begin
      order_q[k_q] <= i_q;
    end
  end

  // result register, colors saturate at the field maximum
  assign total_ext = (FieldW + 1)'(total_q);

  always_ff @(posedge clk_i) begin
    if (post) begin
      colors_q <= (total_ext > {1'b0, ColorsSat}) ? ColorsSat : total_ext[FieldW-1:0];
      fits_q   <= (total_ext <= {1'b0, climit_q});
    end
  end

  assign out_valid_o   = out_valid_q;
  assign colors_used_o = colors_q;
  assign fits_limit_o  = fits_q;

endmodule

`default_nettype wire

// File: src/ggc_check.sv
// ggc_check: port-level assertions for the greedy graph coloring check
// depends on ggc_pkg; bound to the top level at the end of this file
`default_nettype none

module ggc_check
  import ggc_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = 16
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              last_edge_i,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire logic [FieldW-1:0] colors_used_o,
  input wire logic              fits_limit_o
);

  localparam int unsigned MaxColors = (MAX_VERTICES > 31) ? 31 : MAX_VERTICES;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(colors_used_o) &&
    $stable(fits_limit_o))
    else $error("stalled result changed");

  // a last item starts a pass that keeps the input stalled
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_edge_i |=> in_stall_o)
    else $error("input not stalled after last item");

  // a new result is only posted at the end of a pass
  a_post_from_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a coloring pass");

  // never more colors than MAX_VERTICES, nor than the field maximum
  a_color_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> colors_used_o <= FieldW'(MaxColors))
    else $error("colors used above vertex count");

  // an empty coloring always fits
  a_zero_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (colors_used_o == '0) |-> fits_limit_o)
    else $error("zero colors reported as not fitting");

endmodule

bind greedy_graph_coloring_check ggc_check #(
  .MAX_VERTICES(MAX_VERTICES)
) u_ggc_check (.*);

`default_nettype wire
